### hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants for the sphere/box contact block
// widths of the fixed-point fields, pipeline payloads and step functions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sac_pkg;

  localparam int COORD_W    = 24;
  localparam int HALF_W     = COORD_W - 1;
  localparam int EXT_W      = COORD_W + 1;
  localparam int SQR_W      = 2 * COORD_W;
  localparam int SUM_W      = SQR_W + 2;
  localparam int DSQ_W      = 2 * HALF_W;
  localparam int ROOT_W     = HALF_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NFRAC      = 14;
  localparam int NORM_W     = 16;
  localparam int Q_W        = NFRAC + 1;
  localparam int EPS_W      = 12;
  localparam int DIV_STAGES = NFRAC;
  localparam int LATENCY    = 3 + ROOT_W + 1 + DIV_STAGES + 1;

  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1 << NFRAC);

  // register byte address
  localparam logic [2:0] ADDR_NORMAL_EPS = 3'd0;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [HALF_W-1:0]  half_t;

  // beat between front and back
  typedef struct packed {
    logic                  hit;
    logic [DSQ_W-1:0]      dsq;
    logic [2:0][HALF_W-1:0] mag;
    logic [2:0]            dneg;
    logic [2:0][COORD_W-1:0] cp;
    logic [HALF_W-1:0]     r;
    logic                  neg;
  } item_t;

  // square root stage
  typedef struct packed {
    logic                  hit;
    logic [2:0][HALF_W-1:0] mag;
    logic [2:0]            dneg;
    logic [2:0][COORD_W-1:0] cp;
    logic [HALF_W-1:0]     r;
    logic                  neg;
    logic [DSQ_W-1:0]      rad;
    logic [REM_W-1:0]      rem;
    logic [ROOT_W-1:0]     root;
  } sq_t;

  // divide stage
  typedef struct packed {
    logic                  hit;
    logic [HALF_W-1:0]     depth;
    logic                  dflt;
    logic                  neg;
    logic [2:0]            dneg;
    logic [2:0][COORD_W-1:0] cp;
    logic [ROOT_W-1:0]     den;
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0][Q_W-1:0]   q;
  } dv_t;

  // one bit of the digit-by-digit square root
  function automatic sq_t sqrt_step(sq_t s);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] sub;
    sq_t              o;
    o   = s;
    t   = {s.rem, s.rad[DSQ_W-1 -: 2]};
    sub = {2'b00, s.root, 2'b01};
    if (t >= sub) begin
      o.rem  = REM_W'(t - sub);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(t);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.rad = {s.rad[DSQ_W-3:0], 2'b00};
    return o;
  endfunction

  // one quotient bit of restoring division, result {bit, remainder}
  function automatic logic [ROOT_W:0] div_step(logic [ROOT_W-1:0] rem,
                                               logic [ROOT_W-1:0] den);
    logic [ROOT_W:0] t;
    logic [ROOT_W:0] dx;
    t  = {rem, 1'b0};
    dx = {1'b0, den};
    if (t >= dx) return {1'b1, ROOT_W'(t - dx)};
    else return {1'b0, t[ROOT_W-1:0]};
  endfunction

endpackage
`default_nettype wire

### hdl/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front: clamp, square and classify
// clamps the center into the box, squares the deltas and tests against r^2
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sac_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire sac_pkg::coord_t [2:0]   sc,
  input  wire sac_pkg::coord_t [2:0]   bc,
  input  wire sac_pkg::half_t  [2:0]   hx,
  input  wire sac_pkg::half_t          radius,
  input  wire logic                    rev,
  output logic                         push,
  output sac_pkg::item_t               item
);
  import sac_pkg::*;

  logic                      a_v, b_v;
  logic [2:0][COORD_W-1:0]   a_cp, b_cp;
  logic [2:0][COORD_W-1:0]   a_mag;
  logic [2:0]                a_dneg, b_dneg;
  logic [HALF_W-1:0]         a_r, b_r;
  logic                      a_neg, b_neg;
  logic [2:0][SQR_W-1:0]     b_sq;
  logic [2:0][HALF_W-1:0]    b_mag;
  logic [DSQ_W-1:0]          b_rsq;
  logic [2:0][COORD_W-1:0]   cp_c, mag_c;
  logic [2:0]                dneg_c;
  logic [SUM_W-1:0]          dsq_c;

  // per-axis clamp and delta
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [EXT_W-1:0] c, lo, hi, cl, d;
      c  = $signed({sc[i][COORD_W-1], sc[i]});
      lo = $signed({bc[i][COORD_W-1], bc[i]}) - $signed({2'b00, hx[i]});
      hi = $signed({bc[i][COORD_W-1], bc[i]}) + $signed({2'b00, hx[i]});
      cl = c;
      if (cl > hi) cl = hi;
      if (cl < lo) cl = lo;
      d  = c - cl;
      cp_c[i]   = COORD_W'(cl);
      dneg_c[i] = d[EXT_W-1];
      mag_c[i]  = d[EXT_W-1] ? COORD_W'(-d) : COORD_W'(d);
    end
  end

  // stage a: clamped point and delta
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= in_valid;
    a_cp   <= cp_c;
    a_mag  <= mag_c;
    a_dneg <= dneg_c;
    a_r    <= radius;
    a_neg  <= rev;
  end

  // stage b: squares
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    for (int i = 0; i < 3; i++) begin
      b_sq[i]  <= a_mag[i] * a_mag[i];
      b_mag[i] <= a_mag[i][HALF_W-1:0];
    end
    b_rsq  <= a_r * a_r;
    b_cp   <= a_cp;
    b_dneg <= a_dneg;
    b_r    <= a_r;
    b_neg  <= a_neg;
  end

  // sum and compare
  assign dsq_c = SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]) + SUM_W'(b_sq[2]);

  assign push      = b_v;
  assign item.hit  = dsq_c <= SUM_W'(b_rsq);
  assign item.dsq  = dsq_c[DSQ_W-1:0];
  assign item.mag  = b_mag;
  assign item.dneg = b_dneg;
  assign item.cp   = b_cp;
  assign item.r    = b_r;
  assign item.neg  = b_neg;
endmodule
`default_nettype wire

### hdl/sac_queue.sv
// ----------------------------------------------------------------------------
// sac_queue: two-entry queue between front and back
// the back drains one beat per cycle whenever an entry is held
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sac_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sac_pkg::item_t  din,
  output logic                 pop,
  output sac_pkg::item_t       dout,
  output logic                 full
);
  import sac_pkg::*;

  item_t       mem [2];
  logic        wp, rp;
  logic [1:0]  count;

  assign pop  = count != 2'd0;
  assign full = count == 2'd2;
  assign dout = mem[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
endmodule
`default_nettype wire

### hdl/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back: square root, normal divide and result register
// pipelined bit-per-stage square root followed by three pipelined dividers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sac_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire sac_pkg::item_t              item,
  input  wire logic [sac_pkg::EPS_W-1:0]   eps,
  output logic                             done,
  output logic                             hit,
  output logic [sac_pkg::HALF_W-1:0]       depth,
  output logic [2:0][sac_pkg::NORM_W-1:0]  normal,
  output logic [2:0][sac_pkg::COORD_W-1:0] contact
);
  import sac_pkg::*;

  sq_t                     sq [ROOT_W];
  logic [ROOT_W-1:0]       sq_v;
  dv_t                     dv [DIV_STAGES+1];
  dv_t                     dv_next [DIV_STAGES+1];
  logic [DIV_STAGES:0]     dv_v;
  sq_t                     sq_in;
  sq_t                     sq_last;
  dv_t                     dv_in;
  dv_t                     dv_last;
  logic [HALF_W-1:0]       depth_next;
  logic [2:0][NORM_W-1:0]  normal_next;
  logic [2:0][COORD_W-1:0] contact_next;

  // first root stage input
  always_comb begin
    sq_in.hit  = item.hit;
    sq_in.mag  = item.mag;
    sq_in.dneg = item.dneg;
    sq_in.cp   = item.cp;
    sq_in.r    = item.r;
    sq_in.neg  = item.neg;
    sq_in.rad  = item.dsq;
    sq_in.rem  = '0;
    sq_in.root = '0;
  end

  // square root pipeline
  always_ff @(posedge clk) begin
    if (rst) sq_v <= '0;
    else sq_v <= {sq_v[ROOT_W-2:0], in_valid};
    sq[0] <= sqrt_step(sq_in);
    for (int k = 1; k < ROOT_W; k++) sq[k] <= sqrt_step(sq[k-1]);
  end

  // depth, default test and leading quotient bit
  always_comb begin
    logic [ROOT_W-1:0] root_val;
    sq_last     = sq[ROOT_W-1];
    root_val    = sq_last.root;
    dv_in.hit   = sq_last.hit;
    dv_in.depth = HALF_W'(sq_last.r - root_val);
    dv_in.dflt  = root_val <= ROOT_W'(eps);
    dv_in.neg   = sq_last.neg;
    dv_in.dneg  = sq_last.dneg;
    dv_in.cp    = sq_last.cp;
    dv_in.den   = root_val;
    for (int i = 0; i < 3; i++) begin
      if (sq_last.mag[i] >= root_val) begin
        dv_in.rem[i] = sq_last.mag[i] - root_val;
        dv_in.q[i]   = Q_W'(1);
      end else begin
        dv_in.rem[i] = sq_last.mag[i];
        dv_in.q[i]   = '0;
      end
    end
  end

  // next contents of each divide stage
  always_comb begin
    logic [ROOT_W:0] st;
    dv_next[0] = dv_in;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      dv_next[k] = dv[k-1];
      for (int i = 0; i < 3; i++) begin
        st = div_step(dv[k-1].rem[i], dv[k-1].den);
        dv_next[k].rem[i] = st[ROOT_W-1:0];
        dv_next[k].q[i]   = {dv[k-1].q[i][Q_W-2:0], st[ROOT_W]};
      end
    end
  end

  // divide pipeline
  always_ff @(posedge clk) begin
    if (rst) dv_v <= '0;
    else dv_v <= {dv_v[DIV_STAGES-1:0], sq_v[ROOT_W-1]};
    for (int k = 0; k <= DIV_STAGES; k++) dv[k] <= dv_next[k];
  end

  assign dv_last = dv[DIV_STAGES];

  // result fields, zero on a miss
  always_comb begin
    depth_next   = '0;
    normal_next  = '0;
    contact_next = '0;
    if (dv_last.hit) begin
      depth_next   = dv_last.depth;
      contact_next = dv_last.cp;
      if (dv_last.dflt) begin
        normal_next[1] = dv_last.neg ? NORM_W'(-NORM_ONE) : NORM_ONE;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (dv_last.dneg[i] ^ dv_last.neg)
            normal_next[i] = NORM_W'(-{1'b0, dv_last.q[i]});
          else
            normal_next[i] = NORM_W'({1'b0, dv_last.q[i]});
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_v[DIV_STAGES];
    hit     <= dv_last.hit;
    depth   <= depth_next;
    normal  <= normal_next;
    contact <= contact_next;
  end
endmodule
`default_nettype wire

### hdl/sphere_aabb_contact_top.sv
// ----------------------------------------------------------------------------
// sphere_aabb_contact_top: sphere versus axis-aligned box contact test
// front classifies, a short queue decouples, back does root and divide
// ----------------------------------------------------------------------------
// usage
//   a pair is taken at a clock edge with start high and busy low; one beat
//   per cycle is sustained, busy stays low in normal streaming since the
//   back drains the queue every cycle
//   each pair gives one result beat: done is high for exactly one cycle
//   with hit, depth, normal and contact
//   each pair passes through the 23-stage square root (one root bit per stage)
//   and the 15-stage normal divide (one quotient bit per stage)
//   the receiver cannot stall: results are presented once and not held
//   the user writes normal_epsilon over the apb port at byte address 0 only while
//   idle, the block does not enforce this; synchronous reset clears all valid bits
//   and sets normal_epsilon to 0; nothing in flight survives reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sphere_aabb_contact_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sac_pkg::COORD_W-1:0] sphere_center_x,
  input  wire logic [sac_pkg::COORD_W-1:0] sphere_center_y,
  input  wire logic [sac_pkg::COORD_W-1:0] sphere_center_z,
  input  wire logic [sac_pkg::HALF_W-1:0]  sphere_radius,
  input  wire logic [sac_pkg::COORD_W-1:0] box_center_x,
  input  wire logic [sac_pkg::COORD_W-1:0] box_center_y,
  input  wire logic [sac_pkg::COORD_W-1:0] box_center_z,
  input  wire logic [sac_pkg::HALF_W-1:0]  box_half_x,
  input  wire logic [sac_pkg::HALF_W-1:0]  box_half_y,
  input  wire logic [sac_pkg::HALF_W-1:0]  box_half_z,
  input  wire logic                        reverse_order,
  output logic                             done,
  output logic                             hit,
  output logic [sac_pkg::HALF_W-1:0]       depth,
  output logic signed [sac_pkg::NORM_W-1:0]  normal_x,
  output logic signed [sac_pkg::NORM_W-1:0]  normal_y,
  output logic signed [sac_pkg::NORM_W-1:0]  normal_z,
  output logic signed [sac_pkg::COORD_W-1:0] contact_x,
  output logic signed [sac_pkg::COORD_W-1:0] contact_y,
  output logic signed [sac_pkg::COORD_W-1:0] contact_z
);
  import sac_pkg::*;

  logic [EPS_W-1:0]          normal_epsilon;
  logic                      accept;
  logic                      push, pop, full;
  item_t                     f_item, q_item;
  logic [2:0][NORM_W-1:0]    normal;
  logic [2:0][COORD_W-1:0]   contact;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) normal_epsilon <= '0;
    else if (psel && penable && pwrite && paddr == ADDR_NORMAL_EPS)
      normal_epsilon <= pwdata[EPS_W-1:0];
  end
  assign prdata = (paddr == ADDR_NORMAL_EPS) ? 32'(normal_epsilon) : 32'd0;

  assign accept = start && !busy;
  assign busy   = full;

  sac_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_valid (accept),
    .sc     ({sphere_center_z, sphere_center_y, sphere_center_x}),
    .bc     ({box_center_z, box_center_y, box_center_x}),
    .hx     ({box_half_z, box_half_y, box_half_x}),
    .radius (sphere_radius),
    .rev    (reverse_order),
    .push   (push),
    .item   (f_item)
  );

  sac_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (f_item),
    .pop  (pop),
    .dout (q_item),
    .full (full)
  );

  sac_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .item     (q_item),
    .eps      (normal_epsilon),
    .done     (done),
    .hit      (hit),
    .depth    (depth),
    .normal   (normal),
    .contact  (contact)
  );

  assign normal_x  = normal[0];
  assign normal_y  = normal[1];
  assign normal_z  = normal[2];
  assign contact_x = contact[0];
  assign contact_y = contact[1];
  assign contact_z = contact[2];
endmodule
`default_nettype wire

### hdl/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker: port-level checks on the contact block
// latency, miss results and normal range, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sac_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic                       hit,
  input wire logic [sac_pkg::HALF_W-1:0] depth,
  input wire logic signed [sac_pkg::NORM_W-1:0] normal_x,
  input wire logic signed [sac_pkg::NORM_W-1:0] normal_y,
  input wire logic signed [sac_pkg::NORM_W-1:0] normal_z
);
  import sac_pkg::*;

  localparam logic signed [NORM_W-1:0] NMAX = NORM_ONE;
  localparam logic signed [NORM_W-1:0] NMIN = -NORM_ONE;

  // every result beat comes from an earlier accepted pair
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result beat without matching accepted pair");

  // a miss carries zero depth and zero normal
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (depth == '0 && normal_x == '0 && normal_y == '0 &&
                        normal_z == '0))
    else $error("miss result with nonzero fields");

  // normal components stay within unit range
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (normal_x <= NMAX && normal_x >= NMIN &&
                       normal_y <= NMAX && normal_y >= NMIN &&
                       normal_z <= NMAX && normal_z >= NMIN))
    else $error("normal component out of range");
endmodule

bind sphere_aabb_contact_top sac_checker u_sac_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .hit      (hit),
  .depth    (depth),
  .normal_x (normal_x),
  .normal_y (normal_y),
  .normal_z (normal_z)
);
`default_nettype wire

### dv/sphere_aabb_contact_top_tb.sv
// ----------------------------------------------------------------------------
// sphere_aabb_contact_top_tb: self-checking bench for the sphere/box contact
// drives pairs through the start/busy port, predicts hit, depth, normal and
// contact for every accepted beat and checks each done beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sphere_aabb_contact_top_tb;
  import sac_pkg::*;

  localparam int WATCH_LIMIT = 5000;
  localparam int N_RANDOM    = 610;
  localparam int N_STREAM    = 230;

  typedef struct {
    logic [COORD_W-1:0] sc [3];
    logic [HALF_W-1:0]  r;
    logic [COORD_W-1:0] bc [3];
    logic [HALF_W-1:0]  h [3];
    logic               rev;
  } pair_t;

  typedef struct {
    logic               hit;
    logic [HALF_W-1:0]  depth;
    logic [NORM_W-1:0]  n [3];
    logic [COORD_W-1:0] cp [3];
  } contact_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready, start, busy, done, hit;
  logic [COORD_W-1:0] sphere_center_x, sphere_center_y, sphere_center_z;
  logic [HALF_W-1:0] sphere_radius;
  logic [COORD_W-1:0] box_center_x, box_center_y, box_center_z;
  logic [HALF_W-1:0] box_half_x, box_half_y, box_half_z;
  logic reverse_order;
  logic [HALF_W-1:0] depth;
  logic [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic [COORD_W-1:0] contact_x, contact_y, contact_z;

  logic [EPS_W-1:0] eps_shadow;
  contact_t expected_contacts[$];
  bit failed;
  bit idling_on;
  int quiet_cycles;

  sphere_aabb_contact_top i_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor square root, digit by digit
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n   = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // expected contact of one pair under the current epsilon
  function automatic contact_t predict_contact(pair_t p, logic [EPS_W-1:0] eps);
    contact_t o;
    longint sc, lo, hi, c, d [3];
    longint unsigned m, dsq, rsq, root_val, q;
    longint cpv [3];
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      sc = longint'($signed(p.sc[i]));
      lo = longint'($signed(p.bc[i])) - longint'(p.h[i]);
      hi = longint'($signed(p.bc[i])) + longint'(p.h[i]);
      c  = sc;
      if (c > hi) c = hi;
      if (c < lo) c = lo;
      cpv[i] = c;
      d[i]   = sc - c;
      m      = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      dsq   += m * m;
    end
    rsq = longint'(p.r) * longint'(p.r);
    o.hit = 1'b0;
    o.depth = '0;
    for (int i = 0; i < 3; i++) begin
      o.n[i]  = '0;
      o.cp[i] = '0;
    end
    if (dsq <= rsq) begin
      root_val = floor_root(dsq);
      o.hit    = 1'b1;
      o.depth  = HALF_W'(longint'(p.r) - root_val);
      if (root_val > eps) begin
        for (int i = 0; i < 3; i++) begin
          m = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
          q = (m << NFRAC) / root_val;
          if ((d[i] < 0) != p.rev) q = -q;
          o.n[i] = NORM_W'(q);
        end
      end else begin
        o.n[1] = p.rev ? NORM_W'(-(1 << NFRAC)) : NORM_W'(1 << NFRAC);
      end
      for (int i = 0; i < 3; i++) o.cp[i] = COORD_W'(cpv[i]);
    end
    return o;
  endfunction

  // watchdog on accepted beats and results
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("%0t watchdog expired", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t %s mismatch expected %0h actual %0h", $time, name, e, a);
      failed = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    contact_t e;
    if (!rst && done) begin
      if (expected_contacts.size() == 0) begin
        $display("%0t unexpected result beat expected none actual hit=%0b", $time, hit);
        failed = 1'b1;
      end else begin
        e = expected_contacts.pop_front();
        check_field("hit", e.hit, hit);
        check_field("depth", e.depth, depth);
        check_field("normal_x", e.n[0], normal_x);
        check_field("normal_y", e.n[1], normal_y);
        check_field("normal_z", e.n[2], normal_z);
        check_field("contact_x", e.cp[0], contact_x);
        check_field("contact_y", e.cp[1], contact_y);
        check_field("contact_z", e.cp[2], contact_z);
      end
    end
  end

  // lower start for a random burst now and then
  task automatic maybe_idle();
    int n;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // present one pair and hold it until taken
  task automatic send_pair(pair_t p);
    bit taken;
    maybe_idle();
    sphere_center_x <= p.sc[0];
    sphere_center_y <= p.sc[1];
    sphere_center_z <= p.sc[2];
    sphere_radius   <= p.r;
    box_center_x    <= p.bc[0];
    box_center_y    <= p.bc[1];
    box_center_z    <= p.bc[2];
    box_half_x      <= p.h[0];
    box_half_y      <= p.h[1];
    box_half_z      <= p.h[2];
    reverse_order   <= p.rev;
    start           <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        taken = 1'b1;
        expected_contacts = {expected_contacts, predict_contact(p, eps_shadow)};
      end
      @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_contacts.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // apb write of the epsilon register, only while idle
  task automatic write_eps(logic [EPS_W-1:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_NORMAL_EPS; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eps_shadow = v;
    @(negedge clk);
  endtask

  function automatic pair_t make_pair(longint sx, longint sy, longint sz, longint r,
                                      longint bx, longint by, longint bz,
                                      longint hx, longint hy, longint hz, bit rev);
    pair_t p;
    p.sc[0] = COORD_W'(sx); p.sc[1] = COORD_W'(sy); p.sc[2] = COORD_W'(sz);
    p.r = HALF_W'(r);
    p.bc[0] = COORD_W'(bx); p.bc[1] = COORD_W'(by); p.bc[2] = COORD_W'(bz);
    p.h[0] = HALF_W'(hx); p.h[1] = HALF_W'(hy); p.h[2] = HALF_W'(hz);
    p.rev = rev;
    return p;
  endfunction

  // random pair: mostly near the box surface so hits are common
  function automatic pair_t random_pair();
    pair_t p;
    int sb;
    longint span, off;
    p.rev = $urandom_range(0, 1);
    p.r   = HALF_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      p.bc[i] = COORD_W'($urandom);
      p.h[i]  = HALF_W'($urandom);
      p.sc[i] = COORD_W'($urandom);
    end
    if ($urandom_range(0, 4) != 0) begin
      sb = $urandom_range(2, 22);
      p.r = HALF_W'($urandom & ((1 << sb) - 1));
      for (int i = 0; i < 3; i++) begin
        p.h[i] = HALF_W'($urandom & ((1 << $urandom_range(0, sb)) - 1));
        span   = longint'(p.h[i]) + longint'(p.r);
        off    = longint'($urandom) % (2 * span + 1) - span;
        p.sc[i] = COORD_W'(longint'($signed(p.bc[i])) + off);
      end
    end
    return p;
  endfunction

  // extremes and the named corner cases
  task automatic test_directed();
    longint mx, mn, hm;
    mx = (1 << 23) - 1; mn = -(1 << 23); hm = (1 << 23) - 1;
    // center inside the box, both orders
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_pair(make_pair(100, -50, 7, 4096, 0, 0, 0, 4096, 4096, 4096, 1));
    // touching exactly, just outside
    send_pair(make_pair(8192, 0, 0, 4096, 0, 0, 0, 4096, 4096, 4096, 0));
    send_pair(make_pair(8193, 0, 0, 4096, 0, 0, 0, 4096, 4096, 4096, 0));
    send_pair(make_pair(-8192, 0, 0, 4096, 0, 0, 0, 4096, 4096, 4096, 1));
    send_pair(make_pair(0, 0, -9000, 5000, 0, 0, 0, 4096, 4096, 4096, 0));
    send_pair(make_pair(3000, 3000, 3000, 6000, 0, 0, 0, 0, 0, 0, 0));
    // extremes of the coordinates and radius
    send_pair(make_pair(mx, mx, mx, hm, mn, mn, mn, 0, 0, 0, 0));
    send_pair(make_pair(mn, mn, mn, hm, mx, mx, mx, 0, 0, 0, 1));
    send_pair(make_pair(mx, mn, mx, hm, mx, mn, mx, hm, hm, hm, 0));
    // box edges beyond the coordinate range
    send_pair(make_pair(mn, mx, 0, 10, mx, mn, 0, hm, hm, hm, 0));
    send_pair(make_pair(mx, mx, mx, hm, mx, mx, mx, hm, hm, hm, 1));
    send_pair(make_pair(mn, 0, mx, 1, 0, 0, 0, hm, 0, hm, 0));
    send_pair(make_pair(mx, 0, 0, hm, mn, 0, 0, 5, 0, 0, 1));
    send_pair(make_pair(1, -1, 1, 2, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // distance at and above the epsilon for several settings
  task automatic test_epsilon_sweep();
    logic [EPS_W-1:0] eps_list [4];
    eps_list = '{12'd4095, 12'd100, 12'($urandom), 12'd0};
    foreach (eps_list[k]) begin
      write_eps(eps_list[k]);
      send_pair(make_pair(eps_list[k], 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(0, 0, -(eps_list[k] + 1), 8192, 0, 0, 0, 0, 0, 0, 1));
      send_pair(make_pair(eps_list[k] + 7, 3, 0, 8192, 0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 20; i++) send_pair(random_pair());
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 175 == 174) write_eps(12'($urandom));
      send_pair(random_pair());
    end
  endtask

  // back-to-back beats with no gaps
  task automatic test_stream();
    idling_on = 1'b0;
    for (int i = 0; i < N_STREAM; i++) send_pair(random_pair());
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    sphere_center_x = '0; sphere_center_y = '0; sphere_center_z = '0;
    sphere_radius = '0; box_center_x = '0; box_center_y = '0; box_center_z = '0;
    box_half_x = '0; box_half_y = '0; box_half_z = '0; reverse_order = 1'b0;
    eps_shadow = '0; failed = 1'b0; idling_on = 1'b1; quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_epsilon_sweep();
    test_random();
    test_stream();
    drain();
    if (failed) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
